@@ design/rltw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rltw_pkg;

    // Stream widths
    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = 128;
    localparam int RES_W       = 139;
    localparam int OUT_DATA_W  = 144;
    localparam int ENT_OUT_W   = 9;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_QUERY   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV_RD,
        ST_Q_ISSUE,
        ST_Q_DRAIN,
        ST_PEND
    } t_state;

    // One table entry as stored in memory
    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] count;
    } t_entry;

    // Registered memory read beat
    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_rd_beat;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [31:0]          cursor_sample;
        logic [ENT_OUT_W-1:0] cursor_entry;
        logic                 op_ok;
        logic                 cursor_valid;
        logic [31:0]          sample_total;
        logic [63:0]          range_duration;
    } t_result;

endpackage

`default_nettype wire

@@ design/rltw_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rltw_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire rltw_pkg::t_entry  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [AW-1:0]     i_rd_addr,
    output rltw_pkg::t_rd_beat     o_rd
);

    rltw_pkg::t_entry r_mem [0:DEPTH-1];
    rltw_pkg::t_entry r_rd_data;
    logic             r_rd_v;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_rd_en;
        end
    end

    assign o_rd.valid = r_rd_v;
    assign o_rd.ent   = r_rd_data;

endmodule

`default_nettype wire

@@ design/rltw_walk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rltw_walk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_lo,
    input  wire logic [31:0]        i_hi,
    input  wire rltw_pkg::t_rd_beat i_rd,
    output logic [63:0]             o_acc,
    output logic                    o_busy
);

    logic [31:0] r_pos;
    logic        r_live;

    logic        r_s1_v;
    logic [31:0] r_s1_pos;
    logic [31:0] r_s1_before;
    logic [31:0] r_s1_delta;

    logic        r_s2_v;
    logic [31:0] r_s2_span;
    logic [31:0] r_s2_delta;

    logic        r_s3_v;
    logic [63:0] r_s3_prod;

    logic [63:0] r_acc;

    logic [31:0] n_pos;
    logic        w_hit;
    logic        w_stop;
    logic [31:0] w_top;
    logic [31:0] w_before1;
    logic [31:0] w_bottom;
    logic [31:0] w_span;

    // Running end position of each entry (wraps at 32 bits)
    assign n_pos = r_pos + i_rd.ent.count;

    // Overlap of the entry with lo..hi
    assign w_hit     = r_live && (i_lo <= i_hi) && (r_s1_pos >= i_lo);
    assign w_stop    = r_s1_pos >= i_hi;
    assign w_top     = (i_hi < r_s1_pos) ? i_hi : r_s1_pos;
    assign w_before1 = r_s1_before + 32'd1;
    assign w_bottom  = (i_lo > w_before1) ? i_lo : w_before1;
    assign w_span    = w_top - w_bottom + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (i_start) begin
            r_live <= 1'b1;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= i_rd.valid;
            r_s2_v <= r_s1_v && w_hit;
            r_s3_v <= r_s2_v;
            // drop every entry after the one that reaches the range end
            if (r_s1_v && w_hit && w_stop) begin
                r_live <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pos <= 32'd0;
            r_acc <= 64'd0;
        end else begin
            if (i_rd.valid) begin
                r_pos <= n_pos;
            end
            if (r_s3_v) begin
                r_acc <= r_acc + r_s3_prod;
            end
        end
        r_s1_pos    <= n_pos;
        r_s1_before <= r_pos;
        r_s1_delta  <= i_rd.ent.delta;
        r_s2_span   <= w_span;
        r_s2_delta  <= r_s1_delta;
        r_s3_prod   <= {32'd0, r_s2_span} * {32'd0, r_s2_delta};
    end

    assign o_acc  = r_acc;
    assign o_busy = r_s1_v || r_s2_v || r_s3_v;

endmodule

`default_nettype wire

@@ design/run_length_time_table_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Run-length decode-time table with a sample cursor.
// Input stream: one transaction per command; tuser carries the command (clear,
// append, advance, query), tdata the entry count/delta and the query range.
// Output stream: exactly one result transaction per command, in order.
// Handling per command:
//   clear, append, advance within an entry or past the end: answered directly from idle
//   advance into the next entry: one table read for its count, then the answer
//   query: the single table read port streams one entry per cycle into a
//   4-stage overlap/multiply/add pipe, and the answer follows once it drains.
// The result goes to an output register; a second result waits in a pending
// register while the receiver stalls, and the block takes no new command
// until that pending result moves out.
// Reset (synchronous, active low) empties the table and rewinds the cursor;
// the table memory itself is not cleared, since only written entries are read.
// Reads and writes never address the same entry in one cycle: an append writes
// only from idle and every read targets an entry written earlier.
module run_length_time_table_walker #(
    parameter int MAX_ENTRIES = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] entry_count, [63:32] entry_delta, [95:64] first_sample,
    // [127:96] last_sample
    input  wire logic [rltw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [rltw_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [63:0] range_duration, [95:64] sample_total, [96] cursor_valid,
    // [97] op_ok, [106:98] cursor_entry, [138:107] cursor_sample, rest zero
    output logic [rltw_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

    // State registers
    rltw_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_cur, n_cur;
    logic [31:0]      r_off, n_off;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_cur_count, n_cur_count;   // count of the cursor's entry
    logic [CNT_W-1:0] r_k, n_k;                   // query read index
    logic [31:0]      r_lo, n_lo;
    logic [31:0]      r_hi, n_hi;

    // Output register and pending slot
    logic              r_out_v;
    rltw_pkg::t_result r_out;
    rltw_pkg::t_result r_pend;

    // Input fields
    rltw_pkg::t_cmd w_cmd;
    logic [31:0]    w_cnt;
    logic [31:0]    w_dlt;
    logic [31:0]    w_first;
    logic [31:0]    w_last;

    logic w_in_fire;
    logic w_slot_free;

    // Cursor step terms
    logic             w_cur_in;
    logic             w_off_last;
    logic [CNT_W-1:0] w_next_ent;
    logic             w_next_in;
    logic             w_adv_read;

    // Memory and walker interface
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    rltw_pkg::t_entry   w_wr_data;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    rltw_pkg::t_rd_beat w_rd;
    logic               w_start;
    logic [63:0]        w_acc;
    logic               w_busy;
    logic               w_q_done;

    // Result assembly
    logic              w_launch;
    logic              w_ok;
    logic [63:0]       w_dur;
    logic [CNT_W+8:0]  w_ent_ext;
    rltw_pkg::t_result w_res;
    logic              w_load_out;
    logic              w_load_pend;

    assign w_cmd   = rltw_pkg::t_cmd'(s_axis_tuser);
    assign w_cnt   = s_axis_tdata[31:0];
    assign w_dlt   = s_axis_tdata[63:32];
    assign w_first = s_axis_tdata[95:64];
    assign w_last  = s_axis_tdata[127:96];

    assign s_axis_tready = (r_state == rltw_pkg::ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_v || m_axis_tready;

    // Advance: last sample of an existing entry and another entry follows
    assign w_cur_in   = r_cur < r_used;
    assign w_off_last = ({1'b0, r_off} + 33'd1) >= {1'b0, r_cur_count};
    assign w_next_ent = r_cur + CNT_W'(1);
    assign w_next_in  = w_next_ent < r_used;
    assign w_adv_read = w_cur_in && w_off_last && w_next_in;

    // Query finished once no read beat and no walker stage is in flight
    assign w_q_done = !w_rd.valid && !w_busy;

    rltw_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd      (w_rd)
    );

    rltw_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_rd    (w_rd),
        .o_acc   (w_acc),
        .o_busy  (w_busy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rltw_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    case (w_cmd)
                        rltw_pkg::CMD_QUERY: begin
                            n_state = rltw_pkg::ST_Q_ISSUE;
                        end
                        rltw_pkg::CMD_ADVANCE: begin
                            if (w_adv_read) begin
                                n_state = rltw_pkg::ST_ADV_RD;
                            end else if (!w_slot_free) begin
                                n_state = rltw_pkg::ST_PEND;
                            end
                        end
                        default: begin
                            if (!w_slot_free) begin
                                n_state = rltw_pkg::ST_PEND;
                            end
                        end
                    endcase
                end
            end
            rltw_pkg::ST_ADV_RD: begin
                n_state = w_slot_free ? rltw_pkg::ST_IDLE : rltw_pkg::ST_PEND;
            end
            rltw_pkg::ST_Q_ISSUE: begin
                if (r_k >= r_used) begin
                    n_state = rltw_pkg::ST_Q_DRAIN;
                end
            end
            rltw_pkg::ST_Q_DRAIN: begin
                if (w_q_done) begin
                    n_state = w_slot_free ? rltw_pkg::ST_IDLE : rltw_pkg::ST_PEND;
                end
            end
            rltw_pkg::ST_PEND: begin
                if (w_slot_free) begin
                    n_state = rltw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rltw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_used      = r_used;
        n_cur       = r_cur;
        n_off       = r_off;
        n_total     = r_total;
        n_cur_count = r_cur_count;
        n_k         = r_k;
        n_lo        = r_lo;
        n_hi        = r_hi;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_used[AW-1:0];
        w_wr_data   = '{delta: w_dlt, count: w_cnt};
        w_rd_en     = 1'b0;
        w_rd_addr   = w_next_ent[AW-1:0];
        w_start     = 1'b0;
        w_launch    = 1'b0;
        w_ok        = 1'b1;
        w_dur       = 64'd0;
        case (r_state)
            rltw_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    case (w_cmd)
                        rltw_pkg::CMD_CLEAR: begin
                            n_used   = '0;
                            n_cur    = '0;
                            n_off    = 32'd0;
                            n_total  = 32'd0;
                            w_launch = 1'b1;
                        end
                        rltw_pkg::CMD_APPEND: begin
                            w_launch = 1'b1;
                            if (r_used < MAX_C) begin
                                w_wr_en = 1'b1;
                                n_used  = r_used + CNT_W'(1);
                                n_total = r_total + w_cnt;
                                // cursor parked at the end lands on the new entry
                                if (r_cur == r_used) begin
                                    n_cur_count = w_cnt;
                                end
                            end else begin
                                w_ok = 1'b0;
                            end
                        end
                        rltw_pkg::CMD_ADVANCE: begin
                            if (!w_cur_in) begin
                                w_ok     = 1'b0;
                                w_launch = 1'b1;
                            end else if (w_off_last) begin
                                n_cur = w_next_ent;
                                n_off = 32'd0;
                                if (w_next_in) begin
                                    // fetch the next entry's count, answer next cycle
                                    w_rd_en = 1'b1;
                                end else begin
                                    w_ok     = 1'b0;
                                    w_launch = 1'b1;
                                end
                            end else begin
                                n_off    = r_off + 32'd1;
                                w_launch = 1'b1;
                            end
                        end
                        default: begin
                            n_k     = '0;
                            n_lo    = w_first;
                            n_hi    = w_last;
                            w_start = 1'b1;
                        end
                    endcase
                end
            end
            rltw_pkg::ST_ADV_RD: begin
                n_cur_count = w_rd.ent.count;
                w_launch    = 1'b1;
            end
            rltw_pkg::ST_Q_ISSUE: begin
                w_rd_addr = r_k[AW-1:0];
                if (r_k < r_used) begin
                    w_rd_en = 1'b1;
                    n_k     = r_k + CNT_W'(1);
                end
            end
            rltw_pkg::ST_Q_DRAIN: begin
                w_dur    = w_acc;
                w_launch = w_q_done;
            end
            default: begin
            end
        endcase
    end

    // Result from the state after the command
    assign w_ent_ext = {{rltw_pkg::ENT_OUT_W{1'b0}}, n_cur};

    always_comb begin
        w_res.range_duration = w_dur;
        w_res.sample_total   = n_total;
        w_res.cursor_valid   = (n_cur < n_used) && (n_off < n_cur_count);
        w_res.op_ok          = w_ok;
        w_res.cursor_entry   = w_ent_ext[rltw_pkg::ENT_OUT_W-1:0];
        w_res.cursor_sample  = n_off;
    end

    assign w_load_out  = (w_launch && w_slot_free) ||
                         ((r_state == rltw_pkg::ST_PEND) && w_slot_free);
    assign w_load_pend = w_launch && !w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rltw_pkg::ST_IDLE;
            r_used  <= '0;
            r_cur   <= '0;
            r_off   <= 32'd0;
            r_total <= 32'd0;
            r_k     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_cur   <= n_cur;
            r_off   <= n_off;
            r_total <= n_total;
            r_k     <= n_k;
            if (w_load_out) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_count <= n_cur_count;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        if (w_load_out) begin
            r_out <= (r_state == rltw_pkg::ST_PEND) ? r_pend : w_res;
        end
        if (w_load_pend) begin
            r_pend <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(rltw_pkg::OUT_DATA_W - rltw_pkg::RES_W){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import rltw_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int TOTAL_ITEMS   = 450;
    localparam int CALM_TAIL     = 50;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;

    // Input transaction layout, last field in the lowest bits
    typedef struct packed {
        logic [31:0] last_sample;
        logic [31:0] first_sample;
        logic [31:0] entry_delta;
        logic [31:0] entry_count;
    } t_cmd_fields;

    typedef struct {
        t_cmd        cmd;
        t_cmd_fields f;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    run_length_time_table_walker #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the table and cursor
    logic [31:0] tbl_count [TABLE_DEPTH];
    logic [31:0] tbl_delta [TABLE_DEPTH];
    int          n_entries;
    int          cur_ent;
    logic [31:0] cur_off;
    logic [31:0] sample_sum;

    t_result     due_results[$];
    t_dir_row    dir_rows[$];
    int          fail_count;
    int          n_sent;
    int          n_checked;
    int          n_queries;
    int          n_refused;
    int          n_stuck;
    int          gap_pct;
    bit          no_idle;

    function automatic t_result outcome(logic [63:0] dur, logic [31:0] total, logic cv,
                                        logic ok, logic [8:0] ent, logic [31:0] off);
        t_result r;
        r.range_duration = dur;
        r.sample_total   = total;
        r.cursor_valid   = cv;
        r.op_ok          = ok;
        r.cursor_entry   = ent;
        r.cursor_sample  = off;
        return r;
    endfunction

    // Sum delta times overlap of each entry with lo..hi; positions wrap at 32 bits
    function automatic logic [63:0] range_time(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] pos;
        logic [31:0] prev;
        logic [31:0] top;
        logic [31:0] bottom;
        logic [31:0] span;
        logic [63:0] acc;
        pos  = '0;
        prev = '0;
        acc  = '0;
        if (lo > hi)
            return '0;
        for (int k = 0; k < n_entries; k++) begin
            pos = pos + tbl_count[k];
            if (pos >= lo) begin
                top    = (hi < pos) ? hi : pos;
                bottom = prev + 32'd1;
                if (lo > bottom)
                    bottom = lo;
                span = top - bottom + 32'd1;
                acc  = acc + {32'd0, span} * {32'd0, tbl_delta[k]};
                if (pos >= hi)
                    break;
            end
            prev = pos;
        end
        return acc;
    endfunction

    // Apply one command to the shadow state and return the result it causes
    function automatic t_result next_table_result(t_cmd cmd, t_cmd_fields f);
        logic [63:0] dur;
        logic        ok;
        logic        cv;
        dur = '0;
        ok  = 1'b1;
        case (cmd)
            CMD_CLEAR: begin
                n_entries  = 0;
                cur_ent    = 0;
                cur_off    = '0;
                sample_sum = '0;
            end
            CMD_APPEND: begin
                if (n_entries < TABLE_DEPTH) begin
                    tbl_count[n_entries] = f.entry_count;
                    tbl_delta[n_entries] = f.entry_delta;
                    n_entries++;
                    sample_sum = sample_sum + f.entry_count;
                end else begin
                    ok = 1'b0;
                    n_refused++;
                end
            end
            CMD_ADVANCE: begin
                if (cur_ent >= n_entries) begin
                    ok = 1'b0;
                    n_stuck++;
                end else if ({1'b0, cur_off} + 33'd1 >= {1'b0, tbl_count[cur_ent]}) begin
                    cur_ent++;
                    cur_off = '0;
                    ok = (cur_ent < n_entries);
                end else begin
                    cur_off = cur_off + 32'd1;
                end
            end
            default: begin
                dur = range_time(f.first_sample, f.last_sample);
                n_queries++;
            end
        endcase
        cv = (cur_ent < n_entries) && (cur_off < tbl_count[cur_ent]);
        return outcome(dur, sample_sum, cv, ok, cur_ent[8:0], cur_off);
    endfunction

    // Drive one command at the falling edge, hold until accepted, then predict
    task automatic send_cmd(t_cmd cmd, t_cmd_fields f, bit typed, t_result want);
        t_result predicted;
        int      gap;
        gap = 0;
        if (!no_idle && $urandom_range(1, 100) <= gap_pct)
            gap = $urandom_range(1, 18);
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= f;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = next_table_result(cmd, f);
        due_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic send_plain(t_cmd cmd, logic [31:0] cnt, logic [31:0] dlt,
                              logic [31:0] lo, logic [31:0] hi);
        t_cmd_fields f;
        f.entry_count  = cnt;
        f.entry_delta  = dlt;
        f.first_sample = lo;
        f.last_sample  = hi;
        send_cmd(cmd, f, 1'b0, '0);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [31:0] rand_delta();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_append(logic [31:0] cnt);
        send_plain(CMD_APPEND, cnt, rand_delta(), $urandom, $urandom);
    endtask

    // Mostly ranges that land inside the table, some inverted, some anywhere
    task automatic send_query();
        logic [31:0] lim;
        logic [31:0] lo;
        logic [31:0] hi;
        int          r;
        lim = sample_sum + 32'd2;
        r   = $urandom_range(0, 9);
        if (r < 7) begin
            lo = $urandom_range(0, lim);
            hi = $urandom_range(lo, lim);
        end else if (r == 7) begin
            hi = $urandom_range(0, lim);
            lo = hi + $urandom_range(1, 5);
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        send_plain(CMD_QUERY, $urandom, $urandom, lo, hi);
    endtask

    task automatic add_row(t_cmd cmd, logic [31:0] cnt, logic [31:0] dlt,
                           logic [31:0] lo, logic [31:0] hi, bit typed, t_result want);
        t_dir_row row;
        row.cmd            = cmd;
        row.f.entry_count  = cnt;
        row.f.entry_delta  = dlt;
        row.f.first_sample = lo;
        row.f.last_sample  = hi;
        row.typed          = typed;
        row.want           = want;
        dir_rows.push_back(row);
    endtask

    // Fill the table to the brim, refuse more appends, then query across it
    task automatic fill_sweep();
        gap_pct = 10;
        send_plain(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_append($urandom_range(0, 2));
        send_append($urandom_range(0, 2));
        send_append($urandom);
        repeat (3)
            send_plain(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
        send_plain(CMD_QUERY, $urandom, $urandom, 32'd1, sample_sum);
        send_query();
        send_plain(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Short build onto the table (cleared first in some segments), then a mix of mostly cursor steps and queries
    task automatic random_segment();
        int pct_pick;
        int r;
        pct_pick = $urandom_range(0, 2);
        gap_pct  = (pct_pick == 0) ? 0 : (pct_pick == 1) ? 15 : 40;
        if ($urandom_range(0, 2) == 0)
            send_plain(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 10))
            send_append(rand_count());
        repeat ($urandom_range(5, 20)) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_plain(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
            else if (r < 85)
                send_query();
            else if (r < 92)
                send_append(rand_count());
            else if (r < 95)
                send_plain(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else
                send_plain(t_cmd'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Receiver: ready and low in stretches of random length, always ready once no_idle is set
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (no_idle) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(30, 120)) @(negedge i_clk);
                else
                    repeat ($urandom_range(0, 11)) @(negedge i_clk);
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge i_clk);
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RES_W-1:0]);
            if (due_results.size() == 0) begin
                $error("result transaction with nothing outstanding: 0x%0h", got);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                check_field("range_duration", want.range_duration, got.range_duration);
                check_field("sample_total", want.sample_total, got.sample_total);
                check_field("cursor_valid", want.cursor_valid, got.cursor_valid);
                check_field("op_ok", want.op_ok, got.op_ok);
                check_field("cursor_entry", want.cursor_entry, got.cursor_entry);
                check_field("cursor_sample", want.cursor_sample, got.cursor_sample);
                n_checked++;
            end
        end
    end

    // Abort when no transaction moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int rand_base;
        bit filled;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CLEAR;
        fail_count    = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_queries     = 0;
        n_refused     = 0;
        n_stuck       = 0;
        gap_pct       = 20;
        no_idle       = 1'b0;
        filled        = 1'b0;
        n_entries     = 0;
        cur_ent       = 0;
        cur_off       = '0;
        sample_sum    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_count[i] = '0;
            tbl_delta[i] = '0;
        end

        // Directed table: extremes, every command and the corner cases
        add_row(CMD_QUERY,   0, 0, 1, 1, 1, outcome(0, 0, 0, 1, 0, 0));
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1, outcome(0, 0, 0, 0, 0, 0));
        add_row(CMD_APPEND,  3, 10, 0, 0, 1, outcome(0, 3, 1, 1, 0, 0));
        add_row(CMD_APPEND,  0, 7, 0, 0, 1, outcome(0, 3, 1, 1, 0, 0));
        add_row(CMD_APPEND,  2, 32'hFFFF_FFFF, 0, 0, 1, outcome(0, 5, 1, 1, 0, 0));
        add_row(CMD_QUERY,   0, 0, 0, 5, 0, '0);
        add_row(CMD_QUERY,   0, 0, 5, 2, 1, outcome(0, 5, 1, 1, 0, 0));
        add_row(CMD_QUERY,   0, 0, 2, 4, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 1, outcome(0, 5, 0, 0, 3, 0));
        add_row(CMD_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1, outcome(0, 4, 1, 1, 3, 0));
        add_row(CMD_QUERY,   0, 0, 1, 32'hFFFF_FFFF, 0, '0);
        add_row(CMD_QUERY,   0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
        add_row(CMD_QUERY,   0, 0, 0, 0, 0, '0);
        add_row(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1, outcome(0, 0, 0, 1, 0, 0));
        add_row(CMD_APPEND,  1, 0, 0, 0, 0, '0);
        add_row(CMD_ADVANCE, 0, 0, 0, 0, 0, '0);
        add_row(CMD_CLEAR,   0, 0, 0, 0, 1, outcome(0, 0, 0, 1, 0, 0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // Random part with one full-table sweep early on
        rand_base = n_sent;
        while (n_sent < TOTAL_ITEMS) begin
            if (n_sent >= TOTAL_ITEMS - CALM_TAIL)
                no_idle = 1'b1;
            if (!filled && n_sent - rand_base >= 40) begin
                drain_results();
                fill_sweep();
                filled = 1'b1;
            end else begin
                if (!no_idle && $urandom_range(0, 5) == 0)
                    drain_results();
                random_segment();
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked, %0d of them range queries",
                 n_sent, n_checked, n_queries);
        $display("%0d appends refused on a full table, %0d cursor steps past the end",
                 n_refused, n_stuck);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
design/rltw_pkg.sv
design/rltw_table.sv
design/rltw_walk.sv
design/run_length_time_table_walker.sv
test/tb.sv
